@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pfjc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfjc_pkg
// Codes, widths, reset values and result type of the power feed jog controller.
// ----------------------------------------------------------------------------
package pfjc_pkg;

	localparam int SPEED_W = 20;
	localparam int ACCEL_W = 24;
	localparam int STEP_W  = 16;
	localparam int ACT_W   = 4;
	localparam int DELTA_W = 8;
	localparam int CMD_W   = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int REG_W   = ADDR_W - 2;
	// product of a signed delta and an unsigned per-count step
	localparam int PROD_W  = DELTA_W + STEP_W + 1;
	// sum of a speed and the product, signed
	localparam int SUM_W   = PROD_W + 1;

	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
	localparam logic [ACCEL_W-1:0] ACCEL_MAX = '1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_LEFT_ON   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_LEFT_OFF  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_RIGHT_ON  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_RIGHT_OFF = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RAPID_ON  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_RAPID_OFF = 4'd5;
	localparam logic [ACT_W-1:0] ACT_ENCODER   = 4'd6;
	localparam logic [ACT_W-1:0] ACT_UNITS     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_ACCEL_ON  = 4'd8;
	localparam logic [ACT_W-1:0] ACT_ACCEL_OFF = 4'd9;

	// stepper command codes
	localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SPEED = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ACCEL = 3'd4;

	// register indexes
	localparam logic [REG_W-1:0] REG_NORMAL_INIT = 3'd0;
	localparam logic [REG_W-1:0] REG_RAPID_INIT  = 3'd1;
	localparam logic [REG_W-1:0] REG_ACCEL_INIT  = 3'd2;
	localparam logic [REG_W-1:0] REG_SPEED_STEP  = 3'd3;
	localparam logic [REG_W-1:0] REG_MIN_SPEED   = 3'd4;
	localparam logic [REG_W-1:0] REG_ACCEL_STEP  = 3'd5;

	// reset values
	localparam logic [SPEED_W-1:0] RST_NORMAL_SPEED = 20'd1000;
	localparam logic [SPEED_W-1:0] RST_RAPID_SPEED  = 20'd4000;
	localparam logic [ACCEL_W-1:0] RST_ACCEL        = 24'd1000;
	localparam logic [STEP_W-1:0]  RST_SPEED_STEP   = 16'd10;
	localparam logic [SPEED_W-1:0] RST_MIN_SPEED    = 20'd100;
	localparam logic [STEP_W-1:0]  RST_ACCEL_STEP   = 16'd100;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic               direction;
		logic [SPEED_W-1:0] speed_value;
		logic [ACCEL_W-1:0] accel_value;
		logic               left_on;
		logic               right_on;
		logic               rapid_on;
		logic               accel_mode_on;
		logic [SPEED_W-1:0] shown_speed;
		logic               units_pulse;
	} result_t;

endpackage

@@ hw/rtl/power_feed_jog_controller.sv @@
// ----------------------------------------------------------------------------
// power_feed_jog_controller
// Turns table power feed switch and encoder events into stepper commands
// with a snapshot of the mode flags and the displayed speed.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-------------------------------
//  in       | sink      | in_valid/in_ready  | action, encoder_delta
//  out      | source    | out_valid/out_ready| command ... units_pulse
//  apb      | sink      | psel/penable/pready| six setup registers
//
//  one word per cycle sustained while out_ready keeps up; a word taken sits in
//  the input register and moves to the result register, with out_valid high,
//  once that is free; the encoder multiply is done on the way into the input
//  register, the state update and clamps sit between input and result register
//  reset loads the register defaults into the speeds and acceleration; no
//  clearing pass
//  a stalled output holds one word and the input register holds the next
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module power_feed_jog_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	// event input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pfjc_pkg::ACT_W-1:0]    action,
	input  logic signed [pfjc_pkg::DELTA_W-1:0] encoder_delta,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pfjc_pkg::CMD_W-1:0]    command,
	output logic                          direction,
	output logic [pfjc_pkg::SPEED_W-1:0]  speed_value,
	output logic [pfjc_pkg::ACCEL_W-1:0]  accel_value,
	output logic                          left_on,
	output logic                          right_on,
	output logic                          rapid_on,
	output logic                          accel_mode_on,
	output logic [pfjc_pkg::SPEED_W-1:0]  shown_speed,
	output logic                          units_pulse,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfjc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pfjc_pkg::DATA_W-1:0]   pwdata,
	output logic [pfjc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	import pfjc_pkg::*;

	// setup registers
	logic [SPEED_W-1:0] normal_init_q;
	logic [SPEED_W-1:0] rapid_init_q;
	logic [ACCEL_W-1:0] accel_init_q;
	logic [STEP_W-1:0]  speed_step_q;
	logic [SPEED_W-1:0] min_speed_q;
	logic [STEP_W-1:0]  accel_step_q;

	// controller state
	logic               left_q;
	logic               right_q;
	logic               rapid_q;
	logic               accel_mode_q;
	logic [SPEED_W-1:0] normal_speed_q;
	logic [SPEED_W-1:0] rapid_speed_q;
	logic [ACCEL_W-1:0] accel_q;

	// input register
	logic                      valid_s1;
	logic [ACT_W-1:0]          action_s1;
	logic signed [PROD_W-1:0]  prod_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;

	logic [REG_W-1:0] reg_idx;
	logic             cfg_wr;
	logic             advance;

	// next state and result
	logic               left_n;
	logic               right_n;
	logic               rapid_n;
	logic               accel_mode_n;
	logic [SPEED_W-1:0] normal_n;
	logic [SPEED_W-1:0] rapid_speed_n;
	logic [ACCEL_W-1:0] accel_n;
	result_t            res_n;

	logic [SPEED_W-1:0]       base_speed;
	logic signed [SUM_W-1:0]  sum_speed;
	logic [SPEED_W-1:0]       adj_speed;
	logic [ACCEL_W:0]         accel_sum;
	logic [ACCEL_W-1:0]       accel_sat;

	logic start_word;
	logic plain_word;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		case (reg_idx)
			REG_NORMAL_INIT: prdata = DATA_W'(normal_init_q);
			REG_RAPID_INIT:  prdata = DATA_W'(rapid_init_q);
			REG_ACCEL_INIT:  prdata = DATA_W'(accel_init_q);
			REG_SPEED_STEP:  prdata = DATA_W'(speed_step_q);
			REG_MIN_SPEED:   prdata = DATA_W'(min_speed_q);
			REG_ACCEL_STEP:  prdata = DATA_W'(accel_step_q);
			default:         prdata = '0;
		endcase
	end

	// encoder speed adjust: clamp below at the minimum, saturate at the top; acceleration step saturates at the maximum
	always_comb begin
		base_speed = rapid_q ? rapid_speed_q : normal_speed_q;
		sum_speed  = $signed({{(SUM_W-SPEED_W){1'b0}}, base_speed})
			+ {prod_s1[PROD_W-1], prod_s1};
		if (sum_speed < $signed({{(SUM_W-SPEED_W){1'b0}}, min_speed_q})) begin
			adj_speed = min_speed_q;
		end else if (sum_speed > $signed({{(SUM_W-SPEED_W){1'b0}}, SPEED_MAX})) begin
			adj_speed = SPEED_MAX;
		end else begin
			adj_speed = sum_speed[SPEED_W-1:0];
		end
		accel_sum = {1'b0, accel_q} + {{(ACCEL_W+1-STEP_W){1'b0}}, accel_step_q};
		accel_sat = accel_sum[ACCEL_W] ? ACCEL_MAX : accel_sum[ACCEL_W-1:0];
	end

	always_comb begin
		left_n        = left_q;
		right_n       = right_q;
		rapid_n       = rapid_q;
		accel_mode_n  = accel_mode_q;
		normal_n      = normal_speed_q;
		rapid_speed_n = rapid_speed_q;
		accel_n       = accel_q;
		res_n         = '0;
		res_n.command = CMD_NONE;

		if ((action_s1 == ACT_LEFT_ON || action_s1 == ACT_RIGHT_ON) && left_q && right_q) begin
			// press with both directions already set drops both
			left_n  = 1'b0;
			right_n = 1'b0;
		end else begin
			case (action_s1)
				ACT_LEFT_ON, ACT_RIGHT_ON: begin
					if (action_s1 == ACT_LEFT_ON) begin
						left_n = 1'b1;
					end else begin
						right_n = 1'b1;
					end
					if (base_speed != '0) begin
						res_n.command     = CMD_START;
						res_n.direction   = (action_s1 == ACT_RIGHT_ON);
						res_n.speed_value = base_speed;
					end
				end
				ACT_LEFT_OFF: begin
					left_n = 1'b0;
					if (!right_q) begin
						res_n.command = CMD_STOP;
					end
				end
				ACT_RIGHT_OFF: begin
					right_n = 1'b0;
					if (!left_q) begin
						res_n.command = CMD_STOP;
					end
				end
				ACT_RAPID_ON, ACT_RAPID_OFF: begin
					rapid_n = (action_s1 == ACT_RAPID_ON);
					if ((left_q || right_q)
						&& (rapid_n ? rapid_speed_q : normal_speed_q) != '0) begin
						res_n.command     = CMD_SPEED;
						res_n.speed_value = rapid_n ? rapid_speed_q : normal_speed_q;
					end
				end
				ACT_ENCODER: begin
					if (!rapid_q && accel_mode_q) begin
						accel_n           = accel_sat;
						res_n.command     = CMD_ACCEL;
						res_n.accel_value = accel_sat;
					end else begin
						if (rapid_q) begin
							rapid_speed_n = adj_speed;
						end else begin
							normal_n = adj_speed;
						end
						if ((left_q || right_q) && adj_speed != '0) begin
							res_n.command     = CMD_SPEED;
							res_n.speed_value = adj_speed;
						end
					end
				end
				ACT_UNITS: begin
					res_n.units_pulse = 1'b1;
				end
				ACT_ACCEL_ON: begin
					accel_mode_n = 1'b1;
				end
				ACT_ACCEL_OFF: begin
					accel_mode_n = 1'b0;
				end
				default: begin
				end
			endcase
		end

		res_n.left_on       = left_n;
		res_n.right_on      = right_n;
		res_n.rapid_on      = rapid_n;
		res_n.accel_mode_on = accel_mode_n;
		res_n.shown_speed   = rapid_n ? rapid_speed_n : normal_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_init_q  <= RST_NORMAL_SPEED;
			rapid_init_q   <= RST_RAPID_SPEED;
			accel_init_q   <= RST_ACCEL;
			speed_step_q   <= RST_SPEED_STEP;
			min_speed_q    <= RST_MIN_SPEED;
			accel_step_q   <= RST_ACCEL_STEP;
			left_q         <= 1'b0;
			right_q        <= 1'b0;
			rapid_q        <= 1'b0;
			accel_mode_q   <= 1'b0;
			normal_speed_q <= RST_NORMAL_SPEED;
			rapid_speed_q  <= RST_RAPID_SPEED;
			accel_q        <= RST_ACCEL;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NORMAL_INIT: begin
					normal_init_q  <= pwdata[SPEED_W-1:0];
					normal_speed_q <= pwdata[SPEED_W-1:0];
				end
				REG_RAPID_INIT: begin
					rapid_init_q  <= pwdata[SPEED_W-1:0];
					rapid_speed_q <= pwdata[SPEED_W-1:0];
				end
				REG_ACCEL_INIT: begin
					accel_init_q <= pwdata[ACCEL_W-1:0];
					accel_q      <= pwdata[ACCEL_W-1:0];
				end
				REG_SPEED_STEP: speed_step_q <= pwdata[STEP_W-1:0];
				REG_MIN_SPEED:  min_speed_q  <= pwdata[SPEED_W-1:0];
				REG_ACCEL_STEP: accel_step_q <= pwdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end else if (advance) begin
			left_q         <= left_n;
			right_q        <= right_n;
			rapid_q        <= rapid_n;
			accel_mode_q   <= accel_mode_n;
			normal_speed_q <= normal_n;
			rapid_speed_q  <= rapid_speed_n;
			accel_q        <= accel_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			prod_s1   <= PROD_W'(encoder_delta) * PROD_W'($signed({1'b0, speed_step_q}));
		end
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign command       = res_q.command;
	assign direction     = res_q.direction;
	assign speed_value   = res_q.speed_value;
	assign accel_value   = res_q.accel_value;
	assign left_on       = res_q.left_on;
	assign right_on      = res_q.right_on;
	assign rapid_on      = res_q.rapid_on;
	assign accel_mode_on = res_q.accel_mode_on;
	assign shown_speed   = res_q.shown_speed;
	assign units_pulse   = res_q.units_pulse;

	assign start_word = out_valid_q && res_q.command == CMD_START;
	assign plain_word = out_valid_q && res_q.command != CMD_ACCEL;

	`ASSERT_IMPLIES(a_start_speed, start_word, speed_value != '0, "start with zero speed")
	`ASSERT_IMPLIES(a_start_flag, start_word, direction ? right_on : left_on, "start flag clear")
	`ASSERT_IMPLIES(a_accel_only, plain_word, accel_value == '0, "stray acceleration")
	`ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1, "stalled word dropped")

endmodule
